### rtl/core/tcr_pkg.sv
package tcr_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_CYCLE_LENGTH = 2'd0;
    localparam logic [1:0] REG_BAND_COUNT   = 2'd1;

    localparam int CYC_W  = 16;  // cycle length and band width
    localparam int BAND_W = 2;   // band count and band index
    localparam int CHAN_W = 8;   // one colour channel

    localparam logic [CYC_W-1:0]  CYCLE_RESET = 16'd65000;
    localparam logic [CYC_W-1:0]  CYCLE_MIN   = 16'd3;
    localparam logic [BAND_W-1:0] BAND_RESET  = 2'd3;
    localparam logic [CHAN_W-1:0] CHAN_FULL   = 8'hFF;

    // Reciprocal of three for a 16-bit value: (x * RECIP3) >> RECIP3_SH
    localparam logic [CYC_W:0] RECIP3    = 17'd43691;
    localparam int             RECIP3_SH = 17;

    // Band index within the colour ramp
    typedef enum logic [BAND_W-1:0] {
        BAND_FIRST  = 2'd0,
        BAND_SECOND = 2'd1,
        BAND_THIRD  = 2'd2
    } band_t;

endpackage

### rtl/core/tcr_pipe_div.sv
// Pipelined restoring divider: one quotient bit per stage, one word per cycle while en is high.
module tcr_pipe_div import tcr_pkg::*; #(
    parameter int DW = 32,   // dividend width, also the stage count
    parameter int VW = 16,   // divisor width
    parameter int SW = 2     // sideband width
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_dividend,
    input  logic [VW-1:0] in_divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_quot,
    output logic [VW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [DW+1];
    logic [DW-1:0] dvd_reg  [DW+1];
    logic [DW-1:0] quot_reg [DW+1];
    logic [VW-1:0] rem_reg  [DW+1];
    logic [VW-1:0] dsr_reg  [DW+1];
    logic [SW-1:0] side_reg [DW+1];

    // Stage zero is the input itself
    always_comb begin
        vld_reg[0]  = in_valid;
        dvd_reg[0]  = in_dividend;
        quot_reg[0] = '0;
        rem_reg[0]  = '0;
        dsr_reg[0]  = in_divisor;
        side_reg[0] = in_side;
    end

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [VW:0]   trial;
        logic          take;
        logic [VW:0]   diff;
        logic [VW-1:0] rem_next;

        // Shift in one dividend bit and subtract where it fits
        always_comb begin
            trial    = {rem_reg[k], dvd_reg[k][DW-1]};
            take     = (trial >= {1'b0, dsr_reg[k]});
            diff     = trial - {1'b0, dsr_reg[k]};
            rem_next = take ? diff[VW-1:0] : trial[VW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvd_reg[k+1]  <= dvd_reg[k] << 1;
                quot_reg[k+1] <= {quot_reg[k][DW-2:0], take};
                rem_reg[k+1]  <= rem_next;
                dsr_reg[k+1]  <= dsr_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[DW];
    assign out_quot  = quot_reg[DW];
    assign out_rem   = rem_reg[DW];
    assign out_side  = side_reg[DW];

endmodule

### rtl/core/tcr_colour.sv
// Final stage: form the three channels from band index and ramp step.
module tcr_colour import tcr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [BAND_W-1:0] in_bands,
    input  band_t             in_band,
    input  logic [CHAN_W-1:0] in_step,
    output logic              out_valid,
    output logic [3*CHAN_W-1:0] out_rgb
);

    logic              valid_reg;
    logic [CHAN_W-1:0] red_next, green_next, red_reg, green_reg;

    // Edges green, yellow, red (two bands: green, yellow; one band: green); the last band wraps to green
    always_comb begin
        red_next   = '0;
        green_next = CHAN_FULL;
        if (in_bands == 2'd2) begin
            red_next = (in_band == BAND_FIRST) ? in_step : CHAN_FULL - in_step;
        end else if (in_bands == 2'd3) begin
            unique case (in_band)
                BAND_FIRST:  red_next = in_step;
                BAND_SECOND: begin
                    red_next   = CHAN_FULL;
                    green_next = CHAN_FULL - in_step;
                end
                default: begin
                    red_next   = CHAN_FULL - in_step;
                    green_next = in_step;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rgb   = {{CHAN_W{1'b0}}, green_reg, red_reg};

endmodule

### rtl/core/tof_to_color_ramp.sv
// Time-of-flight colour ramp. Takes one 32-bit time-of-flight word and returns
// one RGB word; a new word is taken every cycle while the result side keeps up.
// The path runs through three bit-per-stage divider pipelines (tof modulo cycle
// length, band split, ramp step) and the colour register. The whole pipeline
// stalls together when the output word is held.
// Write the configuration registers only while no word is in flight.
module tof_to_color_ramp import tcr_pkg::*; #(
    parameter int TOF_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // tof
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red, green, blue
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int STEP_W = CYC_W + CHAN_W;

    logic [CYC_W-1:0]  cycle_reg, width_reg, width_next, cyc_eff;
    logic [BAND_W-1:0] bands_reg, bands_eff;
    logic [2*CYC_W:0]  third;
    logic              en;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_reg <= CYCLE_RESET;
            bands_reg <= BAND_RESET;
            width_reg <= CYCLE_RESET / 16'd3;
        end else begin
            width_reg <= width_next;
            if (cfg_valid && cfg_index == REG_CYCLE_LENGTH) cycle_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_BAND_COUNT)   bands_reg <= cfg_data[1:0];
        end
    end

    // Band width, clamped cycle and band count
    always_comb begin
        bands_eff = (bands_reg == 2'd0) ? 2'd1 : bands_reg;
        cyc_eff   = (cycle_reg < CYCLE_MIN) ? CYCLE_MIN : cycle_reg;
        third     = {{CYC_W{1'b0}}, cyc_eff} * {{(CYC_W-1){1'b0}}, RECIP3};
        unique case (bands_eff)
            2'd1:    width_next = cyc_eff;
            2'd2:    width_next = cyc_eff >> 1;
            default: width_next = third[RECIP3_SH +: CYC_W];
        endcase
    end

    // Advance all stages together while the output word is free
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Reduce tof modulo the cycle length
    logic                 d1_valid;
    logic [TOF_WIDTH-1:0] d1_quot;
    logic [CYC_W-1:0]     d1_rem;
    logic [BAND_W-1:0]    d1_bands;

    tcr_pipe_div #(.DW(TOF_WIDTH), .VW(CYC_W), .SW(BAND_W)) u_div_mod (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_dividend(s_tdata[TOF_WIDTH-1:0]),
        .in_divisor(cyc_eff), .in_side(bands_eff),
        .out_valid(d1_valid), .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_bands)
    );

    // Split into band index and remainder
    logic              d2_valid;
    logic [CYC_W-1:0]  d2_quot, d2_rem;
    logic [BAND_W-1:0] d2_bands;

    tcr_pipe_div #(.DW(CYC_W), .VW(CYC_W), .SW(BAND_W)) u_div_band (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d1_valid), .in_dividend(d1_rem),
        .in_divisor(width_reg), .in_side(d1_bands),
        .out_valid(d2_valid), .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_bands)
    );

    // Clamp the band index and scale the remainder by full channel swing
    logic [BAND_W-1:0] band_clamp;
    logic [STEP_W-1:0] scaled;
    always_comb begin
        band_clamp = (d2_quot >= {{(CYC_W-BAND_W){1'b0}}, d2_bands})
                   ? d2_bands - 2'd1 : d2_quot[BAND_W-1:0];
        scaled     = {d2_rem, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, d2_rem};
    end

    // Ramp step = 255 * rem / width
    logic                d3_valid;
    logic [STEP_W-1:0]   d3_quot;
    logic [CYC_W-1:0]    d3_rem;
    logic [2*BAND_W-1:0] d3_side;

    tcr_pipe_div #(.DW(STEP_W), .VW(CYC_W), .SW(2*BAND_W)) u_div_step (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d2_valid), .in_dividend(scaled),
        .in_divisor(width_reg), .in_side({d2_bands, band_clamp}),
        .out_valid(d3_valid), .out_quot(d3_quot), .out_rem(d3_rem), .out_side(d3_side)
    );

    logic unused_bits;
    assign unused_bits = ^{d1_quot, d3_rem, d3_quot[STEP_W-1:CHAN_W]};

    tcr_colour u_colour (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d3_valid), .in_bands(d3_side[2*BAND_W-1:BAND_W]),
        .in_band(band_t'(d3_side[BAND_W-1:0])), .in_step(d3_quot[CHAN_W-1:0]),
        .out_valid(m_tvalid), .out_rgb(m_tdata)
    );

    // Checks
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");
    a_blue_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:16] == 8'd0) else $error("blue nonzero");
    a_width_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        width_reg != '0) else $error("zero band width");

endmodule

### verif/tb_tof_to_color_ramp.sv
`timescale 1ns / 100ps

module tb_tof_to_color_ramp;
    import tcr_pkg::*;

    localparam int PIPE_DEPTH = 32 + 16 + 24 + 1;
    localparam int STALL_LIMIT = 5000;
    localparam logic [23:0] EDGE_GREEN  = 24'h00ff00;
    localparam logic [23:0] EDGE_YELLOW = 24'hffff00;
    localparam logic [23:0] EDGE_RED    = 24'hff0000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CYCLE_LENGTH;
    logic [15:0] cfg_data = '0;

    // Shadow copies of the configuration registers
    logic [15:0] cycle_shadow = CYCLE_RESET;
    logic [1:0]  bands_shadow = BAND_RESET;

    logic [23:0] colour_queue[$];
    int          error_count = 0;
    bit          idling_on = 1'b1;
    bit          hold_request = 1'b0;
    int          quiet_cycles = 0;

    tof_to_color_ramp uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),   // tof
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),   // red, green, blue
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Linear step of one channel, truncating toward zero
    function automatic logic [7:0] ramp_channel(input logic [7:0] base, input logic [7:0] next,
                                                input int rem, input int width);
        int diff;
        int step;
        diff = int'(next) - int'(base);
        step = (diff * rem) / width;
        return 8'((int'(base) + step) & 8'hFF);
    endfunction

    // Expected word: red in the low byte, then green, then blue
    function automatic logic [23:0] ramp_colour(input logic [31:0] tof);
        logic [23:0] edges[3];
        int unsigned bands, cyc, width, pos, band, rem;
        logic [23:0] base, next;
        edges[0] = EDGE_GREEN;
        edges[1] = EDGE_YELLOW;
        edges[2] = EDGE_RED;
        bands = (bands_shadow == 0) ? 1 : bands_shadow;
        cyc = (cycle_shadow < CYCLE_MIN) ? CYCLE_MIN : cycle_shadow;
        width = cyc / bands;
        pos = tof % cyc;
        band = pos / width;
        rem = pos % width;
        if (band >= bands) band = bands - 1;
        base = edges[band % bands];
        next = edges[(band + 1) % bands];
        return {ramp_channel(base[7:0], next[7:0], rem, width),
                ramp_channel(base[15:8], next[15:8], rem, width),
                ramp_channel(base[23:16], next[23:16], rem, width)};
    endfunction

    // Offer one tof word, predict on acceptance, maybe leave a gap after
    task automatic send_tof(input logic [31:0] tof);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= tof;
        do @(posedge aclk); while (!s_tready);
        colour_queue = {colour_queue, ramp_colour(tof)};
        if (idling_on && !hold_request && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every colour has come back and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (colour_queue.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_CYCLE_LENGTH) cycle_shadow = data;
        else if (index == REG_BAND_COUNT) bands_shadow = data[1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_ramp(input logic [15:0] cyc, input logic [1:0] bands);
        drain_results();
        write_reg(REG_CYCLE_LENGTH, cyc);
        write_reg(REG_BAND_COUNT, {14'($urandom), bands});
    endtask

    // Values near band edges and cycle multiples, small values, and some fully random
    function automatic logic [31:0] pick_tof();
        int unsigned cyc, width;
        cyc = (cycle_shadow < CYCLE_MIN) ? CYCLE_MIN : cycle_shadow;
        width = cyc / ((bands_shadow == 0) ? 1 : bands_shadow);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 2 * cyc);
            2: return $urandom_range(0, 65535) * cyc + $urandom_range(0, 3) * width
                      + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 3) * width + $urandom_range(0, 2) - 1
                            + $urandom_range(0, 65535) * cyc;
        endcase
    endfunction

    task automatic test_reset_defaults();
        logic [31:0] picks[14] = '{32'd0, 32'd1, 32'd21665, 32'd21666, 32'd21667,
                                   32'd43332, 32'd43333, 32'd64998, 32'd64999, 32'd65000,
                                   32'd65001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_AAAA};
        foreach (picks[i]) send_tof(picks[i]);
    endtask

    task automatic test_corner_settings();
        logic [15:0] cycs[8] = '{16'd3, 16'd0, 16'd1, 16'd2, 16'd65535, 16'd4, 16'd100, 16'd7};
        logic [1:0]  bnds[8] = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd2, 2'd1};
        foreach (cycs[i]) begin
            set_ramp(cycs[i], bnds[i]);
            repeat (4) send_tof(pick_tof());
            send_tof(32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random_ramps();
        repeat (8) begin
            set_ramp(16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
            repeat (40) send_tof(pick_tof());
        end
    endtask

    // Receiver holds off while words keep coming, so the pipe fills and stalls
    task automatic test_output_hold();
        set_ramp(16'd65535, 2'd3);
        hold_request = 1'b1;
        repeat (120) send_tof(pick_tof());
        s_tvalid <= 1'b0;
        wait (!hold_request);
    endtask

    // Sender waits for every result, then resumes
    task automatic test_sender_pause();
        set_ramp(16'd1000, 2'd2);
        repeat (20) send_tof(pick_tof());
        s_tvalid <= 1'b0;
        while (colour_queue.size() != 0) @(posedge aclk);
        repeat (20) send_tof(pick_tof());
    endtask

    task automatic test_full_rate();
        set_ramp(16'd9, 2'd3);
        idling_on = 1'b0;
        repeat (50) send_tof(pick_tof());
    endtask

    // Result side: random stall bursts, one long hold on request
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                n = $urandom_range(1, 8);
                m_tready <= !(idling_on && $urandom_range(0, 2) == 0);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Compare each colour word with the oldest prediction
    always @(posedge aclk) begin
        logic [23:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (colour_queue.size() == 0) begin
                $display("%0t: unexpected colour, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = colour_queue.pop_front();
                if (m_tdata[7:0] !== want[7:0]) begin
                    $display("%0t: red mismatch, expected %h actual %h",
                             $time, want[7:0], m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== want[15:8]) begin
                    $display("%0t: green mismatch, expected %h actual %h",
                             $time, want[15:8], m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[23:16] !== want[23:16]) begin
                    $display("%0t: blue mismatch, expected %h actual %h",
                             $time, want[23:16], m_tdata[23:16]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL tof_to_color_ramp");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_corner_settings();
        test_random_ramps();
        test_output_hold();
        test_sender_pause();
        test_full_rate();
        drain_results();
        if (error_count == 0 && colour_queue.size() == 0) begin
            $display("PASS tof_to_color_ramp");
        end else begin
            $display("FAIL tof_to_color_ramp");
        end
        $finish;
    end

endmodule
